// ===== hw/rtl/playfair_digraph_encryptor_unit_macros.svh =====
// assertion macros used by the playfair encryptor back end
`ifndef PLAYFAIR_DIGRAPH_ENCRYPTOR_UNIT_MACROS_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPTOR_UNIT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define PFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define PFE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/pfe_pkg.sv =====
// package with shared types, constants and square index helpers
`default_nettype none

package pfe_pkg;

  localparam int Side    = 5;
  localparam int Cells   = 25;
  localparam int Letters = 26;

  localparam logic [4:0] LetterI = 5'd8;
  localparam logic [4:0] LetterJ = 5'd9;
  localparam logic [4:0] LetterZ = 5'd25;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_KEY     = 2'd1,
    OP_FINISH  = 2'd2,
    OP_ENCRYPT = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [4:0] a;
    logic [4:0] b;
  } cmd_t;

  // saturate to z, then fold j onto i
  function automatic logic [4:0] clean_plain(logic [4:0] l);
    logic [4:0] s;
    s = (l > LetterZ) ? LetterZ : l;
    return (s == LetterJ) ? LetterI : s;
  endfunction

  function automatic logic [2:0] cell_row(logic [4:0] c);
    logic [2:0] r;
    if (c >= 5'd20) begin
      r = 3'd4;
    end else if (c >= 5'd15) begin
      r = 3'd3;
    end else if (c >= 5'd10) begin
      r = 3'd2;
    end else if (c >= 5'd5) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  function automatic logic [2:0] cell_col(logic [4:0] c);
    logic [4:0] t;
    t = c - 5'(cell_row(c)) * 5'(Side);
    return t[2:0];
  endfunction

  function automatic logic [4:0] cell_at(logic [2:0] r, logic [2:0] c);
    return 5'(r) * 5'(Side) + 5'(c);
  endfunction

  function automatic logic [2:0] wrap_inc(logic [2:0] x);
    return (x == 3'(Side - 1)) ? 3'd0 : x + 3'd1;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pfe_front.sv =====
// front end: takes transactions, classifies them and queues commands
`default_nettype none

module pfe_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire logic [1:0]    op_i,
  input  wire logic [4:0]    letter_a_i,
  input  wire logic [4:0]    letter_b_i,
  output logic               cmd_valid_o,
  output pfe_pkg::cmd_t      cmd_o,
  input  wire logic          cmd_pop_i
);

  pfe_pkg::cmd_t cmd_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;

  pfe_pkg::op_e  op;
  pfe_pkg::cmd_t cmd_in;
  logic          accept, keep, take;

  assign op     = pfe_pkg::op_e'(op_i);
  assign full   = (count_q == 2'd2);
  assign accept = push && !full;

  // out-of-range key letters have no effect and are dropped here
  assign keep = accept && !(op == pfe_pkg::OP_KEY && letter_a_i > pfe_pkg::LetterZ);
  assign take = cmd_pop_i && (count_q != 2'd0);

  always_comb begin
    cmd_in.op = op;
    cmd_in.a  = letter_a_i;
    cmd_in.b  = letter_b_i;
    unique case (op)
      pfe_pkg::OP_ENCRYPT: begin
        cmd_in.a = pfe_pkg::clean_plain(letter_a_i);
        cmd_in.b = pfe_pkg::clean_plain(letter_b_i);
      end
      pfe_pkg::OP_START, pfe_pkg::OP_KEY, pfe_pkg::OP_FINISH: begin
        cmd_in.b = 5'd0;
      end
      default: begin
        cmd_in.b = 5'd0;
      end
    endcase
  end

  always_comb begin
    wr_ptr_d = keep ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = take ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(keep) - 2'(take);
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      cmd_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = cmd_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== hw/rtl/pfe_back.sv =====
// back end: key square build, fill sequencer, pair lookup and result register
`default_nettype none

`include "playfair_digraph_encryptor_unit_macros.svh"

module pfe_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire pfe_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output logic               empty,
  input  wire logic          pop,
  output logic [4:0]         cipher_a_o,
  output logic [4:0]         cipher_b_o,
  output logic               not_ready_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FILL = 4'b0010,
    S_POS  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  logic [25:0] used_q, used_d;
  logic [4:0]  filled_q, filled_d;
  logic        complete_q, complete_d;
  logic [4:0]  letter_q, letter_d;
  logic        nr_q, nr_d;
  logic        out_valid_q, out_valid_d;
  logic [4:0]  out_a_q, out_b_q;
  logic        out_nr_q;

  logic [4:0]  square_mem [pfe_pkg::Cells];
  logic [4:0]  pos_mem [pfe_pkg::Letters];
  logic [4:0]  pos_a_q, pos_b_q;
  logic [4:0]  sq_a_q, sq_b_q;

  logic        idle_cmd, key_place, fill_place, we;
  logic [4:0]  wr_letter;
  logic        pos_re, sq_re, out_free, out_load;
  logic [2:0]  ra, ca, rb, cb;
  logic [4:0]  oa, ob;

  assign idle_cmd   = (state_q == S_IDLE) && cmd_valid_i;
  assign cmd_pop_o  = idle_cmd;
  assign key_place  = idle_cmd && (cmd_i.op == pfe_pkg::OP_KEY) && !complete_q &&
                      (filled_q < 5'(pfe_pkg::Cells)) && !used_q[cmd_i.a];
  assign fill_place = (state_q == S_FILL) && (filled_q < 5'(pfe_pkg::Cells)) &&
                      !used_q[letter_q];
  assign we         = key_place || fill_place;
  assign wr_letter  = (state_q == S_FILL) ? letter_q : cmd_i.a;
  assign pos_re     = idle_cmd && (cmd_i.op == pfe_pkg::OP_ENCRYPT) && complete_q;
  assign sq_re      = (state_q == S_POS);
  assign out_free   = !out_valid_q || pop;
  assign out_load   = (state_q == S_DONE) && out_free;

  // pair rules on the looked-up cells
  always_comb begin
    ra = pfe_pkg::cell_row(pos_a_q);
    ca = pfe_pkg::cell_col(pos_a_q);
    rb = pfe_pkg::cell_row(pos_b_q);
    cb = pfe_pkg::cell_col(pos_b_q);
    if (ra == rb) begin
      oa = pfe_pkg::cell_at(ra, pfe_pkg::wrap_inc(ca));
      ob = pfe_pkg::cell_at(rb, pfe_pkg::wrap_inc(cb));
    end else if (ca == cb) begin
      oa = pfe_pkg::cell_at(pfe_pkg::wrap_inc(ra), ca);
      ob = pfe_pkg::cell_at(pfe_pkg::wrap_inc(rb), cb);
    end else begin
      oa = pfe_pkg::cell_at(ra, cb);
      ob = pfe_pkg::cell_at(rb, ca);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      square_mem[filled_q] <= wr_letter;
      pos_mem[wr_letter]   <= filled_q;
    end
    if (pos_re) begin
      pos_a_q <= pos_mem[cmd_i.a];
      pos_b_q <= pos_mem[cmd_i.b];
    end
    if (sq_re) begin
      sq_a_q <= square_mem[oa];
      sq_b_q <= square_mem[ob];
    end
  end

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    filled_d    = filled_q;
    complete_d  = complete_q;
    letter_d    = letter_q;
    nr_d        = nr_q;
    out_valid_d = out_valid_q && !pop;
    if (we) begin
      used_d[wr_letter] = 1'b1;
      filled_d          = filled_q + 5'd1;
    end
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            pfe_pkg::OP_START: begin
              used_d     = 26'd1 << pfe_pkg::LetterJ;
              filled_d   = 5'd0;
              complete_d = 1'b0;
            end
            pfe_pkg::OP_KEY: begin
            end
            pfe_pkg::OP_FINISH: begin
              if (!complete_q) begin
                letter_d = 5'd0;
                state_d  = S_FILL;
              end
            end
            pfe_pkg::OP_ENCRYPT: begin
              nr_d    = !complete_q;
              state_d = complete_q ? S_POS : S_DONE;
            end
            default: begin
            end
          endcase
        end
      end
      S_FILL: begin
        letter_d = letter_q + 5'd1;
        if (letter_q == pfe_pkg::LetterZ) begin
          complete_d = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_POS: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_a_q  <= nr_q ? 5'd0 : sq_a_q;
      out_b_q  <= nr_q ? 5'd0 : sq_b_q;
      out_nr_q <= nr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= 26'd1 << pfe_pkg::LetterJ;
      filled_q    <= 5'd0;
      complete_q  <= 1'b0;
      letter_q    <= 5'd0;
      nr_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      filled_q    <= filled_d;
      complete_q  <= complete_d;
      letter_q    <= letter_d;
      nr_q        <= nr_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign empty       = !out_valid_q;
  assign cipher_a_o  = out_a_q;
  assign cipher_b_o  = out_b_q;
  assign not_ready_o = out_nr_q;

  `PFE_ASSERT(a_complete_all_used, complete_q |-> (&used_q), "complete square with unused letter")
  `PFE_ASSERT(a_complete_full, complete_q |-> (filled_q == 5'(pfe_pkg::Cells)), "complete square not full")
  `PFE_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), "result without lookup")
  `PFE_ASSERT_NEVER(a_nr_zero, out_valid_q && out_nr_q && (out_a_q != 5'd0 || out_b_q != 5'd0), "not ready with letters")

endmodule

`default_nettype wire

// ===== hw/rtl/playfair_digraph_encryptor_unit.sv =====
// top level: 5x5 key square playfair pair encryptor
// an encrypt result is registered in the front queue, position lookup, square lookup and
// result register (a not ready one skips both lookups); key and start commands 1 per cycle
// while the back end is idle; encrypt holds it until its result loads, finish for its sweep
// front queue holds 2 commands, result register holds 1 transaction
// reset (async, active low) empties both queues and clears the square to no key
`default_nettype none

module playfair_digraph_encryptor_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] op_i,
  input  wire logic [4:0] letter_a_i,
  input  wire logic [4:0] letter_b_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [4:0]      cipher_a_o,
  output logic [4:0]      cipher_b_o,
  output logic            not_ready_o
);

  logic          cmd_valid;
  logic          cmd_pop;
  pfe_pkg::cmd_t cmd;

  pfe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .letter_a_i  (letter_a_i),
    .letter_b_i  (letter_b_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  pfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .cipher_a_o  (cipher_a_o),
    .cipher_b_o  (cipher_b_o),
    .not_ready_o (not_ready_o)
  );

endmodule

`default_nettype wire
